// ===== hw/rtl/stwd_pkg.sv =====
// shared types, constants and table function for the swept tone with decay core
// no dependencies; imported by every other file of the block
package stwd_pkg;

    // default block parameters
    localparam int unsigned STWD_SAMPLE_RATE = 44100;
    localparam int unsigned STWD_SINE_DEPTH  = 1024;

    // field and datapath widths
    localparam int unsigned CNT_W     = 16;               // counts, frequencies, volume
    localparam int unsigned SMP_W     = 16;               // audio samples
    localparam int unsigned SQ_W      = 2 * CNT_W;        // squared counts
    localparam int unsigned NUM_W     = SQ_W + CNT_W;     // phase numerator
    localparam int unsigned MUL_A_W   = 34;
    localparam int unsigned MUL_B_W   = 19;
    localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
    localparam int unsigned DIV_CNT_W = 6;
    localparam int unsigned FRAC_W    = 8;                // interpolation fraction bits
    localparam int unsigned ENV_FRAC  = 15;               // envelope fraction bits

    // divider defaults for the default sample rate and table depth
    localparam int unsigned STWD_DEN_W = CNT_W + $clog2(STWD_SAMPLE_RATE + 1) + 4;
    localparam int unsigned STWD_QUO_W = $clog2(STWD_SINE_DEPTH) + FRAC_W;

    // arithmetic constants
    localparam logic [63:0]         HALF_PI_Q30    = 64'd1686629713;
    localparam logic [15:0]         AMP_MAX        = 16'd32767;
    localparam logic [15:0]         ENV_ONE        = 16'd32768;
    localparam logic [MUL_B_W-1:0]  MIX_WAVE_GAIN  = 19'd13107;  // 0.4 in Q15
    localparam logic [MUL_B_W-1:0]  MIX_NOISE_GAIN = 19'd19661;  // 0.6 in Q15

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_END     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_ENABLE = 3'd4;

    // configuration reset values
    localparam logic [CNT_W-1:0] FREQ_START_RST   = 16'd9600;
    localparam logic [CNT_W-1:0] FREQ_END_RST     = 16'd19200;
    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 16'd5292;
    localparam logic [CNT_W-1:0] VOLUME_RST       = 16'd11469;

    // input beat
    typedef struct packed {
        logic                    restart;
        logic signed [SMP_W-1:0] noise_value;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    last_sample;
    } t_out_beat;

    // divider control and status
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_FS,
        S_MUL_FE,
        S_ADD_FREQ,
        S_MUL_NUM,
        S_MUL_DEN,
        S_DIV_START,
        S_DIV_MOD,
        S_DIV_POS,
        S_ROM_RD,
        S_MUL_INTERP,
        S_INTERP,
        S_MUL_WAVE,
        S_MUL_NOISE,
        S_MIX_ADD,
        S_MIX_DIV,
        S_ENV_SQ,
        S_ENV_N2,
        S_ENV_DIV,
        S_ENV_WAIT,
        S_MUL_VOL,
        S_MUL_MAG,
        S_OUT
    } t_state;

    // one Q15 sine table entry, quarter wave from a Q30 Taylor series
    // evaluated at elaboration only; depth is 2**log2_depth
    function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                      input int unsigned log2_depth);
        logic [63:0]        d;
        logic [63:0]        q;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        longint             sum;
        logic signed [15:0] res;
        d = 64'd1 << log2_depth;
        q = (64'(k) << 2) >> log2_depth;
        r = (64'(k) << 2) & (d - 64'd1);
        if (q[0]) r = d - r;
        x = (HALF_PI_Q30 * r) >> log2_depth;
        term = x;
        sum  = longint'(x);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        if (sum < 0) sum = 0;
        v = sum;
        v = (v * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) v = 64'd32767;
        res = signed'(v[15:0]);
        if (q >= 64'd2) res = -res;
        return res;
    endfunction

endpackage

// ===== hw/rtl/stwd_sine_rom.sv =====
// sine lookup table with two registered read ports
// depends on stwd_pkg for the entry function
module stwd_sine_rom
    import stwd_pkg::*;
#(
    parameter int unsigned SINE_TABLE_DEPTH = STWD_SINE_DEPTH,
    localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH)
) (
    input  logic                    i_clk,
    input  logic [ADDR_W-1:0]       i_addr0,
    input  logic [ADDR_W-1:0]       i_addr1,
    output logic signed [SMP_W-1:0] o_data0,
    output logic signed [SMP_W-1:0] o_data1
);

    logic signed [SMP_W-1:0] sine_tab [SINE_TABLE_DEPTH];
    logic signed [SMP_W-1:0] r_data0;
    logic signed [SMP_W-1:0] r_data1;

    // constant table contents
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
        assign sine_tab[g] = sine_entry(g, ADDR_W);
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_data0 <= sine_tab[i_addr0];
        r_data1 <= sine_tab[i_addr1];
    end

    assign o_data0 = r_data0;
    assign o_data1 = r_data1;

endmodule

// ===== hw/rtl/stwd_divider.sv =====
// restoring shift-subtract divider, one quotient bit per cycle
// depends on stwd_pkg for control and status types
module stwd_divider
    import stwd_pkg::*;
#(
    parameter int unsigned DEN_W = STWD_DEN_W,
    parameter int unsigned QUO_W = STWD_QUO_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctrl        i_ctrl,
    input  logic [DEN_W-1:0] i_rem_init,
    input  logic [DEN_W-1:0] i_dvsr,
    input  logic [NUM_W-1:0] i_numer,
    output t_div_stat        o_stat,
    output logic [DEN_W-1:0] o_rem,
    output logic [QUO_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_dvsr;
    logic [NUM_W-1:0]     r_numer;
    logic [QUO_W-1:0]     r_quo;

    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;
    logic [DEN_W-1:0]     n_rem;

    // one trial subtraction; numerator bits enter msb first
    assign trial = {r_rem, r_numer[NUM_W-1]};
    assign diff  = trial - {1'b0, r_dvsr};
    assign ge    = (trial >= {1'b0, r_dvsr});
    assign n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctrl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder, numerator and quotient
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem   <= i_rem_init;
            r_dvsr  <= i_dvsr;
            r_numer <= i_numer;
            r_quo   <= '0;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_numer <= {r_numer[NUM_W-2:0], 1'b0};
            r_quo   <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;
    assign o_quo       = r_quo;

endmodule

// ===== hw/rtl/swept_tone_with_decay_core.sv =====
// swept tone with decay: one chirp sample per input beat, shaped by (1-i/n)^2
// sequence per beat: phase remainder divide, table position divide, interpolation, noise
// mixing when enabled, envelope divide (skipped at index zero), volume and magnitude;
// the input stalls until the sequencer has handed the previous sample to the output register
// reset (synchronous, active low) restores the configuration defaults and index zero
// depends on stwd_pkg, stwd_sine_rom and stwd_divider
module swept_tone_with_decay_core
    import stwd_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE      = STWD_SAMPLE_RATE,  // 8000 to 192000
    parameter int unsigned SINE_TABLE_DEPTH = STWD_SINE_DEPTH    // power of two, 64 to 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    localparam int unsigned ADDR_W    = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned RATE_W    = $clog2(SAMPLE_RATE + 1);
    localparam int unsigned DEN_RAW_W = CNT_W + RATE_W + 4;
    localparam int unsigned DEN_W     = (DEN_RAW_W > SQ_W) ? DEN_RAW_W : SQ_W;
    localparam int unsigned POS_W     = ADDR_W + FRAC_W;
    localparam int unsigned QUO_W     = (POS_W > ENV_FRAC) ? POS_W : ENV_FRAC;

    localparam logic [DIV_CNT_W-1:0]      NUM_STEPS = DIV_CNT_W'(NUM_W);
    localparam logic [DIV_CNT_W-1:0]      POS_STEPS = DIV_CNT_W'(POS_W);
    localparam logic [DIV_CNT_W-1:0]      ENV_STEPS = DIV_CNT_W'(ENV_FRAC);
    localparam logic signed [MUL_A_W-1:0] RATE_OPND = MUL_A_W'(SAMPLE_RATE);

    // configuration registers
    logic [CNT_W-1:0] r_freq_start;
    logic [CNT_W-1:0] r_freq_end;
    logic [CNT_W-1:0] r_sample_count;
    logic [CNT_W-1:0] r_volume;
    logic             r_noise_en;

    // control state
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_index;
    logic             r_out_valid;

    // datapath registers
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_i;
    logic                     r_last;
    logic signed [SMP_W-1:0]  r_noise;
    logic signed [PROD_W-1:0] r_prod;
    logic [SQ_W-1:0]          r_acc;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;
    logic signed [SMP_W-1:0]  r_w;
    logic [CNT_W-1:0]         r_e;
    t_out_beat                r_out_data;

    // combinational signals
    logic                      in_accept;
    logic                      out_free;
    logic [CNT_W-1:0]          n_eff;
    logic [CNT_W-1:0]          i_eff;
    logic                      last_eff;
    logic [CNT_W-1:0]          n_minus_i;
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    t_div_ctrl                 div_ctrl;
    t_div_stat                 div_stat;
    logic [DEN_W-1:0]          div_rem_init;
    logic [DEN_W-1:0]          div_dvsr;
    logic [NUM_W-1:0]          div_numer;
    logic [DEN_W-1:0]          div_rem;
    logic [QUO_W-1:0]          div_quo;
    logic [DEN_W-1:0]          den_val;
    logic [ADDR_W-1:0]         rom_addr0;
    logic [ADDR_W-1:0]         rom_addr1;
    logic [FRAC_W-1:0]         interp_frac;
    logic signed [SMP_W-1:0]   rom_s0;
    logic signed [SMP_W-1:0]   rom_s1;
    logic signed [SMP_W:0]     rom_diff;
    logic signed [24:0]        interp_p;
    logic signed [24:0]        interp_b;
    logic signed [24:0]        interp_q;
    logic signed [SMP_W:0]     w_sum;
    logic signed [SQ_W-1:0]    mix_sum;
    logic signed [SQ_W-1:0]    mix_b;
    logic [SMP_W-1:0]          w_abs;
    logic [61:0]               scaled;
    logic [SMP_W:0]            mag_raw;
    logic [SMP_W-1:0]          mag;
    t_out_beat                 out_beat;

    // handshakes; a pending register write goes ahead of the next input beat
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = (r_state == S_IDLE);

    // effective tone length and index of the incoming beat
    assign n_eff    = (r_sample_count == '0) ? CNT_W'(1) : r_sample_count;
    assign i_eff    = (i_in_data.restart || (r_index >= n_eff)) ? '0 : r_index;
    assign last_eff = (i_eff == (n_eff - CNT_W'(1)));

    assign n_minus_i = r_n - r_i;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_start   <= FREQ_START_RST;
            r_freq_end     <= FREQ_END_RST;
            r_sample_count <= SAMPLE_COUNT_RST;
            r_volume       <= VOLUME_RST;
            r_noise_en     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FREQ_START:   r_freq_start   <= i_cfg_data;
                REG_FREQ_END:     r_freq_end     <= i_cfg_data;
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                REG_VOLUME:       r_volume       <= i_cfg_data;
                REG_NOISE_ENABLE: r_noise_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state, sample index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_index <= last_eff ? '0 : i_eff + CNT_W'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (in_accept) n_state = S_MUL_FS;
            S_MUL_FS:     n_state = S_MUL_FE;
            S_MUL_FE:     n_state = S_ADD_FREQ;
            S_ADD_FREQ:   n_state = S_MUL_NUM;
            S_MUL_NUM:    n_state = S_MUL_DEN;
            S_MUL_DEN:    n_state = S_DIV_START;
            S_DIV_START:  n_state = S_DIV_MOD;
            S_DIV_MOD:    if (div_stat.done) n_state = S_DIV_POS;
            S_DIV_POS:    if (div_stat.done) n_state = S_ROM_RD;
            S_ROM_RD:     n_state = S_MUL_INTERP;
            S_MUL_INTERP: n_state = S_INTERP;
            S_INTERP:     n_state = r_noise_en ? S_MUL_WAVE : S_ENV_SQ;
            S_MUL_WAVE:   n_state = S_MUL_NOISE;
            S_MUL_NOISE:  n_state = S_MIX_ADD;
            S_MIX_ADD:    n_state = S_MIX_DIV;
            S_MIX_DIV:    n_state = S_ENV_SQ;
            S_ENV_SQ:     n_state = S_ENV_N2;
            S_ENV_N2:     n_state = S_ENV_DIV;
            S_ENV_DIV:    n_state = (r_i == '0) ? S_MUL_VOL : S_ENV_WAIT;
            S_ENV_WAIT:   if (div_stat.done) n_state = S_MUL_VOL;
            S_MUL_VOL:    n_state = S_MUL_MAG;
            S_MUL_MAG:    n_state = S_OUT;
            S_OUT:        if (out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands and divider requests
    always_comb begin
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_ctrl     = '0;
        div_rem_init = '0;
        div_dvsr     = '0;
        div_numer    = '0;
        case (r_state)
            S_MUL_FS: begin
                mul_en = 1'b1;
                mul_a  = signed'(MUL_A_W'(r_freq_start));
                mul_b  = signed'(MUL_B_W'(n_minus_i));
            end
            S_MUL_FE: begin
                mul_en = 1'b1;
                mul_a  = signed'(MUL_A_W'(r_freq_end));
                mul_b  = signed'(MUL_B_W'(r_i));
            end
            S_MUL_NUM: begin
                mul_en = 1'b1;
                mul_a  = signed'(MUL_A_W'(r_acc));
                mul_b  = signed'(MUL_B_W'(r_i));
            end
            S_MUL_DEN: begin
                mul_en = 1'b1;
                mul_a  = RATE_OPND;
                mul_b  = signed'(MUL_B_W'(r_n));
            end
            S_DIV_START: begin
                div_ctrl.start = 1'b1;
                div_ctrl.steps = NUM_STEPS;
                div_dvsr       = den_val;
                div_numer      = r_num;
            end
            S_DIV_MOD: begin
                if (div_stat.done) begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = POS_STEPS;
                    div_rem_init   = div_rem;
                    div_dvsr       = r_den;
                end
            end
            S_MUL_INTERP: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(rom_diff);
                mul_b  = signed'(MUL_B_W'(interp_frac));
            end
            S_MUL_WAVE: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(r_w);
                mul_b  = signed'(MIX_WAVE_GAIN);
            end
            S_MUL_NOISE: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(r_noise);
                mul_b  = signed'(MIX_NOISE_GAIN);
            end
            S_ENV_SQ: begin
                mul_en = 1'b1;
                mul_a  = signed'(MUL_A_W'(n_minus_i));
                mul_b  = signed'(MUL_B_W'(n_minus_i));
            end
            S_ENV_N2: begin
                mul_en = 1'b1;
                mul_a  = signed'(MUL_A_W'(r_n));
                mul_b  = signed'(MUL_B_W'(r_n));
            end
            S_ENV_DIV: begin
                if (r_i != '0) begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = ENV_STEPS;
                    div_rem_init   = DEN_W'(r_acc);
                    div_dvsr       = DEN_W'(r_prod[SQ_W-1:0]);
                end
            end
            S_MUL_VOL: begin
                mul_en = 1'b1;
                mul_a  = signed'(MUL_A_W'(r_volume));
                mul_b  = signed'(MUL_B_W'(r_e));
            end
            S_MUL_MAG: begin
                mul_en = 1'b1;
                mul_a  = signed'(MUL_A_W'(r_prod[SQ_W-1:0]));
                mul_b  = signed'(MUL_B_W'(w_abs));
            end
            default: ;
        endcase
    end

    // shared multiplier
    assign mul_p = mul_a * mul_b;

    // phase denominator: 16 * n * rate
    assign den_val = {r_prod[DEN_W-5:0], 4'd0};

    // table position from the fractional phase
    assign rom_addr0   = div_quo[POS_W-1:FRAC_W];
    assign rom_addr1   = rom_addr0 + ADDR_W'(1);
    assign interp_frac = div_quo[FRAC_W-1:0];

    // linear interpolation, division by 256 truncated toward zero
    assign rom_diff = (SMP_W + 1)'(rom_s1) - (SMP_W + 1)'(rom_s0);
    assign interp_p = r_prod[24:0];
    assign interp_b = interp_p + (interp_p[24] ? 25'sd255 : 25'sd0);
    assign interp_q = interp_b >>> FRAC_W;
    assign w_sum    = (SMP_W + 1)'(rom_s0) + interp_q[SMP_W:0];

    // noise mix, division by 32768 truncated toward zero on the summed terms
    assign mix_sum = signed'(r_acc) + signed'(r_prod[SQ_W-1:0]);
    assign mix_b   = signed'(r_acc) + (r_acc[SQ_W-1] ? 32'sd32767 : 32'sd0);

    // output scaling by 32767, shift by 45 and saturation
    assign w_abs   = r_w[SMP_W-1] ? unsigned'(-r_w) : unsigned'(r_w);
    assign scaled  = {r_prod[46:0], 15'd0} - 62'(r_prod[46:0]);
    assign mag_raw = scaled[61:45];
    assign mag     = (mag_raw > (SMP_W + 1)'(AMP_MAX)) ? AMP_MAX : mag_raw[SMP_W-1:0];

    assign out_beat.sample_out  = r_w[SMP_W-1] ? signed'(-mag) : signed'(mag);
    assign out_beat.last_sample = r_last;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_n     <= n_eff;
                    r_i     <= i_eff;
                    r_last  <= last_eff;
                    r_noise <= i_in_data.noise_value;
                end
            end
            S_MUL_FE:    r_acc <= r_prod[SQ_W-1:0];
            S_ADD_FREQ:  r_acc <= r_acc + r_prod[SQ_W-1:0];
            S_MUL_DEN:   r_num <= r_prod[NUM_W-1:0];
            S_DIV_START: r_den <= den_val;
            S_INTERP:    r_w   <= w_sum[SMP_W-1:0];
            S_MUL_NOISE: r_acc <= r_prod[SQ_W-1:0];
            S_MIX_ADD:   r_acc <= unsigned'(mix_sum);
            S_MIX_DIV:   r_w   <= mix_b[30:15];
            S_ENV_N2:    r_acc <= r_prod[SQ_W-1:0];
            S_ENV_DIV:   if (r_i == '0) r_e <= ENV_ONE;
            S_ENV_WAIT:  if (div_stat.done) r_e <= CNT_W'(div_quo[ENV_FRAC-1:0]);
            S_OUT:       if (out_free) r_out_data <= out_beat;
            default: ;
        endcase
    end

    // sine table
    stwd_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_addr0 (rom_addr0),
        .i_addr1 (rom_addr1),
        .o_data0 (rom_s0),
        .o_data1 (rom_s1)
    );

    // shared divider
    stwd_divider #(
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_rem_init (div_rem_init),
        .i_dvsr     (div_dvsr),
        .i_numer    (div_numer),
        .o_stat     (div_stat),
        .o_rem      (div_rem),
        .o_quo      (div_quo)
    );

    // divider runs only while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_DIV_MOD || r_state == S_DIV_POS ||
                           r_state == S_ENV_WAIT))
        else $error("divider busy outside a divide wait state");

    // the index of an accepted beat lies inside the tone, last flag agrees
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_i < r_n) && (r_last == (r_i == r_n - CNT_W'(1))))
        else $error("sample index outside the tone");

    // envelope never exceeds one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_VOL) |-> (r_e <= ENV_ONE))
        else $error("envelope above unity");

    // saturated output never reaches the most negative code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sample_out != 16'sh8000))
        else $error("output sample out of range");

endmodule
